[sv/tmhq_pkg.sv]
`timescale 1ns / 1ps
package tmhq_pkg;

    localparam int CAPACITY  = 64;
    localparam int ID_BITS   = 16;
    localparam int TIME_BITS = 48;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int NOW_W     = 48;
    localparam int DELAY_W   = 32;
    localparam int TID_W     = 16;
    localparam int FCNT_W    = 7;

    typedef enum logic [1:0] {
        OP_SCHED  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] exp;
        logic [ID_BITS-1:0]   id;
    } entry_t;

    typedef struct packed {
        op_t               kind;
        logic [TID_W-1:0]  timer_id;
        logic              ok;
        logic              fired;
        logic [FCNT_W-1:0] fired_count;
        logic              last;
    } result_t;

endpackage

[sv/tmhq_ram.sv]
`timescale 1ns / 1ps
module tmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/tmhq_ctrl.sv]
`timescale 1ns / 1ps
module tmhq_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tmhq_pkg::op_t                     in_kind,
    input  logic [tmhq_pkg::NOW_W-1:0]        in_now,
    input  logic [tmhq_pkg::DELAY_W-1:0]      in_delay,
    input  logic [tmhq_pkg::TID_W-1:0]        in_cid,
    input  logic                              out_free,
    output logic                              emit,
    output tmhq_pkg::result_t                 emit_res,
    output logic                              ram_we,
    output logic [tmhq_pkg::IDX_W-1:0]        ram_waddr,
    output tmhq_pkg::entry_t                  ram_wdata,
    output logic [tmhq_pkg::IDX_W-1:0]        ram_raddr,
    input  tmhq_pkg::entry_t                  ram_rdata
);
    import tmhq_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_RISE_RD  = 10'b0000000010,
        ST_RISE_CHK = 10'b0000000100,
        ST_CAN_CHK  = 10'b0000001000,
        ST_MOVE_CHK = 10'b0000010000,
        ST_SINK_RD  = 10'b0000100000,
        ST_SINK_L   = 10'b0001000000,
        ST_SINK_R   = 10'b0010000000,
        ST_TICK_RD  = 10'b0100000000,
        ST_TICK_CHK = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [ID_BITS-1:0]   cid_reg, cid_next;
    entry_t               cur_reg, cur_next;
    entry_t               left_reg, left_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic [IDX_W-1:0]     start_reg, start_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ID_BITS-1:0]   pend_id_reg, pend_id_next;
    logic [CNT_W-1:0]     fire_cnt_reg, fire_cnt_next;

    logic [TIME_BITS:0]   sum;
    logic [ID_BITS-1:0]   id_inc;
    logic [IDX_W:0]       lchild;
    logic [IDX_W:0]       rchild;
    logic [IDX_W-1:0]     parent;
    logic [CNT_W-1:0]     cnt_dec;
    logic                 fires;
    logic                 do_stop;
    logic                 do_finish;
    entry_t               pick;
    logic [IDX_W-1:0]     pick_idx;

    always_comb begin
        sum      = {1'b0, in_now[TIME_BITS-1:0]} + (TIME_BITS + 1)'(in_delay);
        id_inc   = next_id_reg + 1'b1;
        lchild   = {i_reg, 1'b1};
        rchild   = lchild + 1'b1;
        parent   = (i_reg - 1'b1) >> 1;
        cnt_dec  = count_reg - 1'b1;
        fires    = (count_reg != '0) && (ram_rdata.exp <= now_reg);
        if (left_reg.exp < ram_rdata.exp) begin
            pick     = left_reg;
            pick_idx = lchild[IDX_W-1:0];
        end else begin
            pick     = ram_rdata;
            pick_idx = rchild[IDX_W-1:0];
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        cid_next        = cid_reg;
        cur_next        = cur_reg;
        left_next       = left_reg;
        i_next          = i_reg;
        start_next      = start_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        fire_cnt_next   = fire_cnt_reg;
        in_ready        = 1'b0;
        emit            = 1'b0;
        emit_res        = '0;
        ram_we          = 1'b0;
        ram_waddr       = i_reg;
        ram_wdata       = cur_reg;
        ram_raddr       = '0;
        do_stop         = 1'b0;
        do_finish       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = out_free;
                if (in_valid && out_free) begin
                    op_next = in_kind;
                    case (in_kind)
                        OP_SCHED: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                emit              = 1'b1;
                                emit_res.kind     = OP_SCHED;
                                emit_res.last     = 1'b1;
                            end else begin
                                cur_next.exp = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                                cur_next.id  = next_id_reg;
                                i_next       = count_reg[IDX_W-1:0];
                                count_next   = count_reg + 1'b1;
                                next_id_next = (id_inc == '0) ? ID_BITS'(1) : id_inc;
                                state_next   = ST_RISE_RD;
                            end
                        end
                        OP_CANCEL: begin
                            cid_next   = in_cid[ID_BITS-1:0];
                            k_next     = '0;
                            state_next = ST_CAN_CHK;
                        end
                        OP_TICK: begin
                            now_next        = in_now[TIME_BITS-1:0];
                            pend_valid_next = 1'b0;
                            fire_cnt_next   = '0;
                            state_next      = ST_TICK_CHK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RISE_RD: begin
                if (i_reg == '0) begin
                    ram_we    = 1'b1;
                    do_finish = 1'b1;
                end else begin
                    ram_raddr  = parent;
                    state_next = ST_RISE_CHK;
                end
            end
            ST_RISE_CHK: begin
                ram_we = 1'b1;
                if (cur_reg.exp < ram_rdata.exp) begin
                    ram_wdata  = ram_rdata;
                    i_next     = parent;
                    state_next = ST_RISE_RD;
                end else begin
                    do_finish = 1'b1;
                end
            end
            ST_CAN_CHK: begin
                if ((CNT_W'(k_reg) < count_reg) && (ram_rdata.id == cid_reg)) begin
                    count_next = cnt_dec;
                    if (CNT_W'(k_reg) == cnt_dec) begin
                        emit              = 1'b1;
                        emit_res.kind     = OP_CANCEL;
                        emit_res.timer_id = TID_W'(cid_reg);
                        emit_res.ok       = 1'b1;
                        emit_res.last     = 1'b1;
                        state_next        = ST_IDLE;
                    end else begin
                        i_next     = k_reg;
                        start_next = k_reg;
                        ram_raddr  = cnt_dec[IDX_W-1:0];
                        state_next = ST_MOVE_CHK;
                    end
                end else if (CNT_W'(k_reg) + 1'b1 >= count_reg) begin
                    emit              = 1'b1;
                    emit_res.kind     = OP_CANCEL;
                    emit_res.timer_id = TID_W'(cid_reg);
                    emit_res.last     = 1'b1;
                    state_next        = ST_IDLE;
                end else begin
                    k_next    = k_reg + 1'b1;
                    ram_raddr = k_reg + 1'b1;
                end
            end
            ST_MOVE_CHK: begin
                cur_next   = ram_rdata;
                state_next = ST_SINK_RD;
            end
            ST_SINK_RD: begin
                if ((IDX_W + 2)'(lchild) >= (IDX_W + 2)'(count_reg)) begin
                    do_stop = 1'b1;
                end else begin
                    ram_raddr  = lchild[IDX_W-1:0];
                    state_next = ST_SINK_L;
                end
            end
            ST_SINK_L: begin
                left_next = ram_rdata;
                if ((IDX_W + 2)'(rchild) < (IDX_W + 2)'(count_reg)) begin
                    ram_raddr  = rchild[IDX_W-1:0];
                    state_next = ST_SINK_R;
                end else if (ram_rdata.exp < cur_reg.exp) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    i_next     = lchild[IDX_W-1:0];
                    state_next = ST_SINK_RD;
                end else begin
                    do_stop = 1'b1;
                end
            end
            ST_SINK_R: begin
                if (pick.exp < cur_reg.exp) begin
                    ram_we     = 1'b1;
                    ram_wdata  = pick;
                    i_next     = pick_idx;
                    state_next = ST_SINK_RD;
                end else begin
                    do_stop = 1'b1;
                end
            end
            ST_TICK_RD: begin
                state_next = ST_TICK_CHK;
            end
            ST_TICK_CHK: begin
                if (out_free || (fires && !pend_valid_reg)) begin
                    if (fires) begin
                        if (pend_valid_reg) begin
                            emit              = 1'b1;
                            emit_res.kind     = OP_TICK;
                            emit_res.timer_id = TID_W'(pend_id_reg);
                            emit_res.ok       = 1'b1;
                            emit_res.fired    = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = ram_rdata.id;
                        fire_cnt_next   = fire_cnt_reg + 1'b1;
                        count_next      = cnt_dec;
                        if (cnt_dec == '0) begin
                            state_next = ST_TICK_RD;
                        end else begin
                            i_next     = '0;
                            start_next = '0;
                            ram_raddr  = cnt_dec[IDX_W-1:0];
                            state_next = ST_MOVE_CHK;
                        end
                    end else begin
                        emit          = 1'b1;
                        emit_res.kind = OP_TICK;
                        emit_res.ok   = 1'b1;
                        emit_res.last = 1'b1;
                        if (pend_valid_reg) begin
                            emit_res.timer_id    = TID_W'(pend_id_reg);
                            emit_res.fired       = 1'b1;
                            emit_res.fired_count = FCNT_W'(fire_cnt_reg);
                        end
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_stop) begin
            if (i_reg == start_reg) begin
                state_next = ST_RISE_RD;
            end else begin
                ram_we    = 1'b1;
                ram_wdata = cur_reg;
                do_finish = 1'b1;
            end
        end

        if (do_finish) begin
            case (op_reg)
                OP_SCHED: begin
                    emit              = 1'b1;
                    emit_res.kind     = OP_SCHED;
                    emit_res.timer_id = TID_W'(cur_reg.id);
                    emit_res.ok       = 1'b1;
                    emit_res.last     = 1'b1;
                    state_next        = ST_IDLE;
                end
                OP_CANCEL: begin
                    emit              = 1'b1;
                    emit_res.kind     = OP_CANCEL;
                    emit_res.timer_id = TID_W'(cid_reg);
                    emit_res.ok       = 1'b1;
                    emit_res.last     = 1'b1;
                    state_next        = ST_IDLE;
                end
                default: begin
                    state_next = ST_TICK_RD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_NONE;
            count_reg      <= '0;
            next_id_reg    <= ID_BITS'(1);
            pend_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            pend_valid_reg <= pend_valid_next;
            fire_cnt_reg   <= fire_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        cid_reg     <= cid_next;
        cur_reg     <= cur_next;
        left_reg    <= left_next;
        i_reg       <= i_next;
        start_reg   <= start_next;
        k_reg       <= k_next;
        pend_id_reg <= pend_id_next;
    end

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("heap count above capacity");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result produced while output word still held");

    a_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_id_reg != '0)
        else $error("next id is zero");

    a_pend_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (fire_cnt_reg != '0))
        else $error("pending fired timer without count");

endmodule

[sv/timer_min_heap_queue_top.sv]
`timescale 1ns / 1ps
// schedule sifts the new timer up the heap, cancel scans the heap for the id before sifting
// tick: each fired timer is taken off the heap root and the heap is sifted again, through the one heap ram read port
// throughput: one word at a time, the next input word is taken once the previous one is done
// results leave through an output register, a held result word keeps the input waiting
// reset: aresetn synchronous active low, empties the heap and sets the next id to one
module timer_min_heap_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // now[47:0], delay[79:48], cancel_id[95:80]
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // timer_id[15:0], ok[16], fired[17], fired_count[24:18]
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast
);
    import tmhq_pkg::*;

    logic    m_valid_reg;
    result_t res_reg;
    logic    out_free;
    logic    emit;
    result_t emit_res;
    logic    ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    entry_t  ram_wdata;
    entry_t  ram_rdata;

    assign out_free = !m_valid_reg || m_tready;

    tmhq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (op_t'(s_tuser)),
        .in_now    (s_tdata[47:0]),
        .in_delay  (s_tdata[79:48]),
        .in_cid    (s_tdata[95:80]),
        .out_free  (out_free),
        .emit      (emit),
        .emit_res  (emit_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tmhq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_reg <= emit_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {7'd0, res_reg.fired_count, res_reg.fired, res_reg.ok, res_reg.timer_id};

endmodule

[dv/timer_min_heap_queue_top_test.sv]
`timescale 1ns / 1ps
module timer_min_heap_queue_top_test;
    import tmhq_pkg::*;

    typedef struct packed {
        op_t               kind;
        logic [TID_W-1:0]  timer_id;
        logic              ok;
        logic              fired;
        logic [FCNT_W-1:0] fired_count;
        logic              last;
    } answer_t;

    typedef struct {
        op_t                kind;
        logic [NOW_W-1:0]   now;
        logic [DELAY_W-1:0] delay;
        logic [TID_W-1:0]   cid;
        logic               has_ans;
        answer_t            ans;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    timer_min_heap_queue_top uut (.*);

    localparam logic [NOW_W-1:0] TMAX = '1;

    // timer queue shadow
    logic [TIME_BITS-1:0] q_exp [CAPACITY];
    logic [ID_BITS-1:0]   q_id [CAPACITY];
    int                   q_cnt;
    logic [ID_BITS-1:0]   q_next;

    answer_t answer_q[$];
    row_t    rows[$];
    int      errors;
    bit      stall_free;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic answer_t mk(op_t k, int id, bit ok, bit fd, int fc, bit l);
        answer_t a;
        a.kind = k; a.timer_id = TID_W'(id); a.ok = ok; a.fired = fd;
        a.fired_count = FCNT_W'(fc); a.last = l;
        return a;
    endfunction

    function automatic void queue_answer(answer_t a);
        answer_q.insert(answer_q.size(), a);
    endfunction

    function automatic void swap_at(int a, int b);
        logic [TIME_BITS-1:0] e;
        logic [ID_BITS-1:0]   t;
        e = q_exp[a]; t = q_id[a];
        q_exp[a] = q_exp[b]; q_id[a] = q_id[b];
        q_exp[b] = e; q_id[b] = t;
    endfunction

    function automatic void float_up(int j);
        int p;
        while (j > 0) begin
            p = (j - 1) / 2;
            if (!(q_exp[j] < q_exp[p])) break;
            swap_at(p, j);
            j = p;
        end
    endfunction

    function automatic void take_out(int i);
        int n, k, l, c;
        n = q_cnt - 1;
        if (i != n) begin
            q_exp[i] = q_exp[n];
            q_id[i] = q_id[n];
            k = i;
            forever begin
                l = 2 * k + 1;
                if (l >= n) break;
                c = l;
                if (l + 1 < n && !(q_exp[l] < q_exp[l + 1])) c = l + 1;
                if (!(q_exp[c] < q_exp[k])) break;
                swap_at(k, c);
                k = c;
            end
            if (k == i) float_up(i);
        end
        q_cnt = n;
    endfunction

    function automatic void predict_timers(op_t kind, logic [NOW_W-1:0] now,
                                           logic [DELAY_W-1:0] delay,
                                           logic [TID_W-1:0] cid);
        logic [NOW_W:0] sum;
        int             fc;
        answer_t        a;
        bit             hit;
        case (kind)
            OP_SCHED: begin
                if (q_cnt >= CAPACITY) begin
                    queue_answer(mk(OP_SCHED, 0, 0, 0, 0, 1));
                end else begin
                    sum = now + delay;
                    q_exp[q_cnt] = (sum > TMAX) ? TMAX : sum[NOW_W-1:0];
                    q_id[q_cnt] = q_next;
                    queue_answer(mk(OP_SCHED, q_next, 1, 0, 0, 1));
                    q_next = q_next + 1'b1;
                    if (q_next == 0) q_next = 1;
                    q_cnt++;
                    float_up(q_cnt - 1);
                end
            end
            OP_CANCEL: begin
                hit = 0;
                for (int i = 0; i < q_cnt; i++) begin
                    if (!hit && q_id[i] == cid) begin
                        take_out(i);
                        hit = 1;
                    end
                end
                queue_answer(mk(OP_CANCEL, cid, hit, 0, 0, 1));
            end
            OP_TICK: begin
                fc = 0;
                while (q_cnt > 0 && q_exp[0] <= now) begin
                    a = mk(OP_TICK, q_id[0], 1, 1, 0, 0);
                    take_out(0);
                    queue_answer(a);
                    fc++;
                end
                if (fc == 0) begin
                    queue_answer(mk(OP_TICK, 0, 1, 0, 0, 1));
                end else begin
                    answer_q[$].fired_count = FCNT_W'(fc);
                    answer_q[$].last = 1;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(op_t kind, logic [NOW_W-1:0] now, logic [DELAY_W-1:0] delay,
                             logic [TID_W-1:0] cid);
        while (!stall_free && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {cid, delay, now};
        do @(posedge aclk); while (!s_tready);
        predict_timers(kind, now, delay, cid);
    endtask

    task automatic drain_all();
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= stall_free ? 1'b1 : ($urandom_range(99) >= 29);
            if (m_tvalid && m_tready) begin
                answer_t a;
                a = mk(op_t'(m_tuser), m_tdata[15:0], m_tdata[16], m_tdata[17],
                       m_tdata[24:18], m_tlast);
                if (answer_q.size() == 0) begin
                    report("unexpected result word");
                end else begin
                    answer_t e;
                    e = answer_q.pop_front();
                    if (a.kind !== e.kind) report($sformatf("kind %0d exp %0d", a.kind, e.kind));
                    if (a.timer_id !== e.timer_id)
                        report($sformatf("timer_id %0d exp %0d", a.timer_id, e.timer_id));
                    if (a.ok !== e.ok) report($sformatf("ok %0b exp %0b", a.ok, e.ok));
                    if (a.fired !== e.fired)
                        report($sformatf("fired %0b exp %0b", a.fired, e.fired));
                    if (a.fired_count !== e.fired_count)
                        report($sformatf("fired_count %0d exp %0d", a.fired_count, e.fired_count));
                    if (a.last !== e.last) report($sformatf("last %0b exp %0b", a.last, e.last));
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic row_t r(op_t k, logic [NOW_W-1:0] n, logic [DELAY_W-1:0] d,
                               logic [TID_W-1:0] c);
        row_t x;
        x.kind = k; x.now = n; x.delay = d; x.cid = c; x.has_ans = 0;
        return x;
    endfunction

    function automatic row_t rk(op_t k, logic [NOW_W-1:0] n, logic [DELAY_W-1:0] d,
                                logic [TID_W-1:0] c, answer_t a);
        row_t x;
        x = r(k, n, d, c);
        x.has_ans = 1; x.ans = a;
        return x;
    endfunction

    function automatic void add_row(row_t x);
        rows.insert(rows.size(), x);
    endfunction

    initial begin
        row_t  w;
        op_t   k;
        int    sel, items;
        logic [NOW_W-1:0] clk_now;
        logic [TID_W-1:0] id_pick;

        errors = 0;
        stall_free = 0;
        q_cnt = 0;
        q_next = 1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_SCHED;
        m_tready = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(rk(OP_TICK, TMAX, 0, 0, mk(OP_TICK, 0, 1, 0, 0, 1)));
        add_row(rk(OP_CANCEL, 0, 0, 16'hffff, mk(OP_CANCEL, 16'hffff, 0, 0, 0, 1)));
        add_row(rk(OP_SCHED, 0, 0, 0, mk(OP_SCHED, 1, 1, 0, 0, 1)));
        add_row(rk(OP_SCHED, TMAX, 32'hffffffff, 0, mk(OP_SCHED, 2, 1, 0, 0, 1)));
        add_row(r(OP_SCHED, 100, 50, 0));
        add_row(r(OP_SCHED, 100, 50, 0));
        add_row(r(OP_SCHED, 10, 140, 0));
        add_row(r(OP_SCHED, 48'h7fff_0000_0000, 32'h8000_0000, 0));
        add_row(r(OP_NONE, TMAX, 32'hffffffff, 16'hffff));
        add_row(rk(OP_CANCEL, 0, 0, 4, mk(OP_CANCEL, 4, 1, 0, 0, 1)));
        add_row(rk(OP_CANCEL, 0, 0, 4, mk(OP_CANCEL, 4, 0, 0, 0, 1)));
        add_row(r(OP_TICK, 149, 0, 0));
        add_row(r(OP_TICK, 150, 0, 0));
        add_row(r(OP_CANCEL, 0, 0, 2));
        add_row(r(OP_TICK, TMAX, 0, 0));
        add_row(r(OP_TICK, 0, 0, 0));
        foreach (rows[i]) begin
            w = rows[i];
            send_word(w.kind, w.now, w.delay, w.cid);
            if (w.has_ans && answer_q.size() != 0 && w.ans !== answer_q[$])
                report($sformatf("directed row %0d disagrees with prediction", i));
        end

        // fill to full, overflow, then one tick empties all 64
        for (int i = 0; i < CAPACITY + 2; i++)
            send_word(OP_SCHED, 1000, $urandom_range(500), 0);
        if (answer_q[$] !== mk(OP_SCHED, 0, 0, 0, 0, 1)) report("full heap not predicted");
        send_word(OP_TICK, TMAX, 0, 0);
        drain_all();

        // back to back burst with no idling
        stall_free = 1;
        repeat (40) begin
            send_word(OP_SCHED, 0, $urandom_range(3000), 0);
        end
        stall_free = 0;
        send_word(OP_CANCEL, 0, 0, 1);
        drain_all();

        clk_now = 2000;
        items = 0;
        while (items < 130) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                k = OP_SCHED;
            end else if (sel < 70) begin
                k = OP_CANCEL;
            end else if (sel < 95) begin
                k = OP_TICK;
            end else begin
                k = OP_NONE;
            end
            if ($urandom_range(9) == 0) begin
                clk_now = NOW_W'({$urandom, $urandom});
            end else begin
                clk_now = clk_now + $urandom_range(60);
            end
            if (k == OP_CANCEL && q_cnt > 0 && $urandom_range(3) != 0) begin
                id_pick = q_id[$urandom_range(q_cnt - 1)];
            end else begin
                id_pick = TID_W'($urandom);
            end
            if ($urandom_range(15) == 0) begin
                send_word(k, clk_now, $urandom, id_pick);
            end else begin
                send_word(k, clk_now, $urandom_range(200), id_pick);
            end
            if (k != OP_NONE) items++;
            if (items == 65) begin
                drain_all();
                stall_free = 1;
            end
            if (items == 100) stall_free = 0;
        end
        send_word(OP_TICK, TMAX, 0, 0);
        drain_all();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
